>>> hw/rtl/long_alarm_timer_extender_macros.svh
// Assertion macros for the long alarm timer extender.
`ifndef LONG_ALARM_TIMER_EXTENDER_MACROS_SVH
`define LONG_ALARM_TIMER_EXTENDER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define LTX_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ltx: same-cycle check failed");
`define LTX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ltx: next-cycle check failed");
`else
`define LTX_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LTX_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hw/rtl/ltx_pkg.sv
// Shared types and constants of the long alarm timer extender.
`timescale 1ns / 1ps

package ltx_pkg;

  localparam int NSEC_W     = 30;
  localparam int OUT_SEC_W  = 32;
  localparam int OPCODE_W   = 2;
  localparam int CFG_ADDR_W = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [NSEC_W:0]   NS_PER_S  = 31'd1000000000;
  localparam logic [NSEC_W-1:0] NS_MAX    = 30'd999999999;
  localparam logic [NSEC_W-1:0] HALF_S_NS = 30'd500000000;

  localparam logic [NSEC_W-1:0] MIN_NSEC_RST = 30'd1000;
  localparam logic [NSEC_W-1:0] MAX_NSEC_RST = 30'd50000000;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SET_ALARM = 2'd0,
    OP_GET_TIME  = 2'd1,
    OP_SET_TIME  = 2'd2,
    OP_EXPIRY    = 2'd3
  } op_t;

  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_SEC  = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_NSEC = 8'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_SEC  = 8'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_NSEC = 8'd3;

  typedef struct packed {
    logic [OUT_SEC_W-1:0] now_sec;
    logic [NSEC_W-1:0]    now_nsec;
    logic                 reload_valid;
    logic [OUT_SEC_W-1:0] reload_sec;
    logic [NSEC_W-1:0]    reload_nsec;
    logic                 alarm_fire;
  } result_t;

  function automatic logic [NSEC_W-1:0] sat_ns(logic [NSEC_W-1:0] v);
    sat_ns = (v > NS_MAX) ? NS_MAX : v;
  endfunction

endpackage

>>> hw/rtl/ltx_ifs.sv
// Request, result and configuration channel interfaces.
`timescale 1ns / 1ps

interface ltx_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [ltx_pkg::OPCODE_W-1:0]           opcode;
  logic [ltx_pkg::OUT_SEC_W-1:0]          arg_sec;
  logic [ltx_pkg::NSEC_W-1:0]             arg_nsec;
  logic [ltx_pkg::OUT_SEC_W-1:0]          remain_sec;
  logic [ltx_pkg::NSEC_W-1:0]             remain_nsec;

  modport source (output valid, opcode, arg_sec, arg_nsec, remain_sec, remain_nsec,
                  input ready);
  modport sink (input valid, opcode, arg_sec, arg_nsec, remain_sec, remain_nsec,
                output ready);
endinterface

interface ltx_out_if;
  logic                          valid;
  logic                          ready;
  logic [ltx_pkg::OUT_SEC_W-1:0] now_sec;
  logic [ltx_pkg::NSEC_W-1:0]    now_nsec;
  logic                          reload_valid;
  logic [ltx_pkg::OUT_SEC_W-1:0] reload_sec;
  logic [ltx_pkg::NSEC_W-1:0]    reload_nsec;
  logic                          alarm_fire;

  modport source (output valid, now_sec, now_nsec, reload_valid, reload_sec, reload_nsec,
                  alarm_fire, input ready);
  modport sink (input valid, now_sec, now_nsec, reload_valid, reload_sec, reload_nsec,
                alarm_fire, output ready);
endinterface

interface ltx_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ltx_pkg::CFG_ADDR_W-1:0] addr;
  logic [ltx_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

>>> hw/rtl/long_alarm_timer_extender.sv
// Top level of the long alarm timer extender.
`timescale 1ns / 1ps
`include "long_alarm_timer_extender_macros.svh"

// One request per clock cycle is accepted unless the request side stalls, and
// each produces one result: a request register feeds a single combinational pass
// (seconds/nanoseconds adders with carry and borrow, then the interval compares)
// that updates the clock, alarm delay and counter load and fills the result register.
// Outside reset, requests stall only while both registers are full and the result
// is not being taken. Configuration writes are accepted every cycle outside reset.
module long_alarm_timer_extender #(
  parameter int SECONDS_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  ltx_in_if.sink          in_ch,
  ltx_out_if.source       out_ch,
  ltx_cfg_if.sink         cfg_ch
);

  localparam int SW = SECONDS_WIDTH;
  localparam int NW = ltx_pkg::NSEC_W;

  typedef struct packed {
    logic [SW-1:0] s;
    logic [NW-1:0] n;
  } tv_t;

  typedef struct packed {
    logic under;
    tv_t  d;
  } sub_t;

  function automatic tv_t t_add(tv_t a, tv_t b);
    tv_t         r;
    logic [NW:0] n;
    n   = {1'b0, a.n} + {1'b0, b.n};
    r.s = a.s + b.s;
    if (n >= ltx_pkg::NS_PER_S) begin
      n   = n - ltx_pkg::NS_PER_S;
      r.s = r.s + SW'(1);
    end
    r.n = n[NW-1:0];
    return r;
  endfunction

  function automatic sub_t t_sub(tv_t a, tv_t b);
    sub_t        r;
    logic        bor;
    logic [NW:0] n;
    logic [SW:0] sd;
    bor = (a.n < b.n);
    if (bor) begin
      n = {1'b0, a.n} + ltx_pkg::NS_PER_S - {1'b0, b.n};
    end else begin
      n = {1'b0, a.n} - {1'b0, b.n};
    end
    sd      = {1'b0, a.s} - {1'b0, b.s} - {{SW{1'b0}}, bor};
    r.under = sd[SW];
    r.d.s   = sd[SW-1:0];
    r.d.n   = n[NW-1:0];
    return r;
  endfunction

  function automatic logic t_less(tv_t a, tv_t b);
    return (a.s < b.s) || ((a.s == b.s) && (a.n < b.n));
  endfunction

  // Request register
  logic           s1_valid_r;
  ltx_pkg::op_t   s1_op_r;
  tv_t            s1_arg_r;
  tv_t            s1_rem_r;

  // Timekeeping state and configuration
  tv_t            clock_r, clock_nxt;
  tv_t            delay_r, delay_nxt;
  tv_t            load_r, load_nxt;
  logic           armed_r, armed_nxt;
  tv_t            min_r, max_r;

  // Result register
  logic             out_valid_r;
  ltx_pkg::result_t out_r;
  ltx_pkg::result_t res_nxt;

  logic s1_fire;
  logic in_fire;
  tv_t  half_min;
  tv_t  now_v;
  sub_t lr;
  sub_t dsub;
  logic reload;
  logic fire;

  assign s1_fire      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = rst_n && (!s1_valid_r || s1_fire);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = rst_n;

  assign half_min.s = min_r.s >> 1;
  assign half_min.n = (min_r.n >> 1) + (min_r.s[0] ? ltx_pkg::HALF_S_NS : '0);

  always_comb begin
    clock_nxt = clock_r;
    delay_nxt = delay_r;
    load_nxt  = load_r;
    armed_nxt = armed_r;
    now_v     = '0;
    reload    = 1'b0;
    fire      = 1'b0;
    lr        = t_sub(load_r, s1_rem_r);
    dsub      = t_sub(delay_r, load_r);
    case (s1_op_r)
      ltx_pkg::OP_SET_ALARM: begin
        clock_nxt = t_add(clock_r, lr.d);
        delay_nxt = t_less(s1_arg_r, min_r) ? min_r : s1_arg_r;
        armed_nxt = 1'b1;
        load_nxt  = t_less(max_r, delay_nxt) ? max_r : delay_nxt;
        reload    = 1'b1;
      end
      ltx_pkg::OP_GET_TIME: begin
        now_v = t_add(lr.d, clock_r);
      end
      ltx_pkg::OP_SET_TIME: begin
        clock_nxt = s1_arg_r;
        load_nxt  = max_r;
        reload    = 1'b1;
        fire      = armed_r;
        armed_nxt = 1'b0;
      end
      ltx_pkg::OP_EXPIRY: begin
        clock_nxt = t_add(clock_r, load_r);
        if (armed_r) begin
          delay_nxt = dsub.d;
          reload    = 1'b1;
          if (dsub.under || !t_less(half_min, dsub.d)) begin
            load_nxt  = max_r;
            armed_nxt = 1'b0;
            fire      = 1'b1;
          end else if (t_less(dsub.d, min_r)) begin
            load_nxt = min_r;
          end else if (t_less(dsub.d, max_r)) begin
            load_nxt = dsub.d;
          end else begin
            load_nxt = max_r;
          end
        end
      end
      default: begin
        reload = 1'b0;
      end
    endcase

    res_nxt.now_sec      = ltx_pkg::OUT_SEC_W'(now_v.s);
    res_nxt.now_nsec     = now_v.n;
    res_nxt.reload_valid = reload;
    res_nxt.reload_sec   = reload ? ltx_pkg::OUT_SEC_W'(load_nxt.s) : '0;
    res_nxt.reload_nsec  = reload ? load_nxt.n : '0;
    res_nxt.alarm_fire   = fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r    <= ltx_pkg::op_t'(in_ch.opcode);
      s1_arg_r.s <= SW'(in_ch.arg_sec);
      s1_arg_r.n <= ltx_pkg::sat_ns(in_ch.arg_nsec);
      s1_rem_r.s <= SW'(in_ch.remain_sec);
      s1_rem_r.n <= ltx_pkg::sat_ns(in_ch.remain_nsec);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r   <= '0;
      delay_r.s <= '0;
      delay_r.n <= ltx_pkg::MAX_NSEC_RST;
      load_r.s  <= '0;
      load_r.n  <= ltx_pkg::MAX_NSEC_RST;
      armed_r   <= 1'b0;
    end else if (s1_fire) begin
      clock_r <= clock_nxt;
      delay_r <= delay_nxt;
      load_r  <= load_nxt;
      armed_r <= armed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r.s <= '0;
      min_r.n <= ltx_pkg::MIN_NSEC_RST;
      max_r.s <= '0;
      max_r.n <= ltx_pkg::MAX_NSEC_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.addr)
        ltx_pkg::CFG_MIN_SEC:  min_r.s <= SW'(cfg_ch.data);
        ltx_pkg::CFG_MIN_NSEC: min_r.n <= ltx_pkg::sat_ns(cfg_ch.data[NW-1:0]);
        ltx_pkg::CFG_MAX_SEC:  max_r.s <= SW'(cfg_ch.data);
        ltx_pkg::CFG_MAX_NSEC: max_r.n <= ltx_pkg::sat_ns(cfg_ch.data[NW-1:0]);
        default: begin
          min_r <= min_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.now_sec      = out_r.now_sec;
  assign out_ch.now_nsec     = out_r.now_nsec;
  assign out_ch.reload_valid = out_r.reload_valid;
  assign out_ch.reload_sec   = out_r.reload_sec;
  assign out_ch.reload_nsec  = out_r.reload_nsec;
  assign out_ch.alarm_fire   = out_r.alarm_fire;

  `LTX_ASSERT_IMPL(a_fire_has_reload, clk, rst_n, out_valid_r && out_r.alarm_fire, out_r.reload_valid)
  `LTX_ASSERT_NEXT(a_get_time_quiet, clk, rst_n, s1_fire && (s1_op_r == ltx_pkg::OP_GET_TIME), !out_r.reload_valid && !out_r.alarm_fire)
  `LTX_ASSERT_NEXT(a_fire_needs_armed, clk, rst_n, s1_fire && !armed_r, !out_r.alarm_fire)
  `LTX_ASSERT_NEXT(a_set_alarm_arms, clk, rst_n, s1_fire && (s1_op_r == ltx_pkg::OP_SET_ALARM), armed_r && out_r.reload_valid)

endmodule
